// ===== hw/rtl/lcg_keystream_xor_cipher_defines.svh =====
// Assertion macros for the LCG keystream XOR cipher.
`ifndef LCG_KEYSTREAM_XOR_CIPHER_DEFINES_SVH
`define LCG_KEYSTREAM_XOR_CIPHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LKXC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LKXC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkxc_pkg.sv =====
// Shared types and constants for the LCG keystream XOR cipher.
`timescale 1ns / 1ps

package lkxc_pkg;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam logic [31:0] LCG_MOD = 32'h7FFF_FFFF;

  typedef logic [31:0] key_t;
  typedef logic [7:0]  byte_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SEQ_LOW   = 2'd0,
    REG_USER_CSUM = 2'd1,
    REG_PASS_CSUM = 2'd2
  } reg_idx_t;

  // One input word as held in the input stage
  typedef struct packed {
    byte_t data_byte;
    logic  start_message;
  } item_t;

endpackage

// ===== hw/rtl/lkxc_key_step.sv =====
// One LCG step: low 32 bits of key*MUL+ADD, then folded modulo 2^31-1.
`timescale 1ns / 1ps

module lkxc_key_step
  import lkxc_pkg::*;
(
  input  key_t key_in,
  output key_t key_out
);

  key_t prod;
  key_t wrapped;
  key_t folded;

  assign prod    = key_in * LCG_MUL;
  assign wrapped = prod + LCG_ADD;

  // 2^31 == 1 mod (2^31-1): add top bit into the low 31 bits, then one correction
  assign folded  = {1'b0, wrapped[30:0]} + {31'd0, wrapped[31]};
  assign key_out = (folded >= LCG_MOD) ? (folded - LCG_MOD) : folded;

endmodule

// ===== hw/rtl/lkxc_in_stage.sv =====
// Input register stage: captures one word, holds it until the core takes it.
`timescale 1ns / 1ps

module lkxc_in_stage
  import lkxc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_data_byte,
  input  logic  in_start_message,
  input  logic  take,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall  = valid_r & ~take;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte     <= in_data_byte;
      item_r.start_message <= in_start_message;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hw/rtl/lcg_keystream_xor_cipher.sv =====
// LCG keystream XOR cipher top level: one byte in, one transformed byte out.
// Path from input accept to output: input register, then result register.
// Throughput: one word per cycle while out_stall is low; the key register, one
//   32x32 multiply and a modulo fold form the loop that sets this rate.
// Reset (rst_n low, synchronous): key, position, config registers and all
//   valid flags clear to zero.
`timescale 1ns / 1ps
`include "lcg_keystream_xor_cipher_defines.svh"

module lcg_keystream_xor_cipher
  import lkxc_pkg::*;
#(
  parameter int MESSAGE_BYTES = 256
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic        out_last_byte
);

  localparam int POS_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MESSAGE_BYTES - 1);

  logic [15:0] seq_low_r;
  logic [7:0]  user_csum_r;
  logic [7:0]  pass_csum_r;

  key_t             key_r, key_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic  out_valid_r, out_valid_nxt;
  byte_t out_data_r;
  logic  out_last_r;

  logic  s1_valid;
  item_t s1_item;
  logic  advance;
  key_t  key_base;
  logic [POS_W-1:0] cur_pos;
  logic  is_last;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_low_r   <= 16'd0;
      user_csum_r <= 8'd0;
      pass_csum_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEQ_LOW:   seq_low_r   <= cfg_data;
        REG_USER_CSUM: user_csum_r <= cfg_data[7:0];
        REG_PASS_CSUM: pass_csum_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or being taken
  assign advance = s1_valid & (~out_valid_r | ~out_stall);

  lkxc_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_message (in_start_message),
    .take             (advance),
    .s1_valid         (s1_valid),
    .s1_item          (s1_item)
  );

  // Start reseeds the key before the step
  assign key_base = s1_item.start_message ? {seq_low_r, user_csum_r, pass_csum_r} : key_r;

  lkxc_key_step u_key_step (
    .key_in  (key_base),
    .key_out (key_nxt)
  );

  assign cur_pos = s1_item.start_message ? '0 : pos_r;
  assign is_last = (cur_pos == LAST_POS);
  assign pos_nxt = is_last ? '0 : cur_pos + POS_W'(1);

  assign out_valid_nxt = advance | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        key_r <= key_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= s1_item.data_byte ^ key_nxt[7:0];
      out_last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_last_byte = out_last_r;

  `LKXC_ASSERT_NOW(a_key_reduced, 1'b1, key_r < LCG_MOD, "key register not reduced modulo 2^31-1")
  `LKXC_ASSERT_NEXT(a_pos_wrap, advance && is_last, pos_r == '0, "position did not wrap after last byte")
  `LKXC_ASSERT_NEXT(a_word_kept, s1_valid && !advance, s1_valid, "held input word lost")
  `LKXC_ASSERT_NOW(a_stall_cause, in_stall, s1_valid && out_valid_r && out_stall, "stall without full pipe")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LCG keystream XOR cipher: predicts each output word.
module tb_top
  import lkxc_pkg::*;
();

  localparam int MSG_BYTES = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_NONE = 2'd3;  // unmapped index, write must be dropped

  typedef struct packed {
    byte_t data_out;
    logic  last_byte;
  } cipher_word_t;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_start_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_last_byte;

  // Shadow of the block's registers and keystream state
  logic [15:0] seq_low_q = '0;
  byte_t       user_csum_q = '0;
  byte_t       pass_csum_q = '0;
  key_t        key_q = '0;
  int unsigned pos_q = 0;

  cipher_word_t expected_words[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  bit           gaps_on = 1'b1;
  stall_mode_t  stall_mode = STALL_OFF;
  logic [7:0]   stall_tick = '0;

  always #4 clk = ~clk;

  lcg_keystream_xor_cipher #(.MESSAGE_BYTES(MSG_BYTES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_message (in_start_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_out     (out_data_out),
    .out_last_byte    (out_last_byte)
  );

  function automatic key_t lcg_next(key_t k);
    key_t w;
    w = k * LCG_MUL + LCG_ADD;  // wraps at 32 bits
    return w % LCG_MOD;
  endfunction

  function automatic void set_reg(logic [1:0] idx, logic [15:0] value);
    case (idx)
      REG_SEQ_LOW:   seq_low_q = value;
      REG_USER_CSUM: user_csum_q = value[7:0];
      REG_PASS_CSUM: pass_csum_q = value[7:0];
      default: ;
    endcase
  endfunction

  function automatic cipher_word_t cipher_byte(byte_t data, logic start);
    cipher_word_t w;
    if (start) begin
      key_q = {seq_low_q, user_csum_q, pass_csum_q};
      pos_q = 0;
    end
    key_q = lcg_next(key_q);
    w.data_out = data ^ key_q[7:0];
    w.last_byte = (pos_q + 1 >= MSG_BYTES);
    pos_q = w.last_byte ? 0 : pos_q + 1;
    return w;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender bursts: random run length, then a random gap
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = gaps_on ? $urandom_range(1, 5) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
      end
    end
  endtask

  task automatic send_byte(byte_t data, logic start);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_start_message <= start;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(cipher_byte(data, start));
    pace();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Key runs from its reset value of zero before any start
  task automatic test_unseeded_stream();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain();
  endtask

  // All-ones and all-zeros seeds, oversized values, ignored index
  task automatic test_seed_extremes();
    write_reg(REG_SEQ_LOW, 16'hFFFF);
    write_reg(REG_USER_CSUM, 16'hFFFF);
    write_reg(REG_PASS_CSUM, 16'h01FF);
    write_reg(REG_NONE, 16'h1234);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();
    write_reg(REG_SEQ_LOW, 16'h0000);
    write_reg(REG_USER_CSUM, 16'hFF00);
    write_reg(REG_PASS_CSUM, 16'h0000);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7F, 1'b0);
    drain();
  endtask

  // New seed must not disturb the running key until the next start
  task automatic test_write_mid_message();
    write_reg(REG_SEQ_LOW, 16'h8001);
    write_reg(REG_USER_CSUM, 16'h003C);
    write_reg(REG_PASS_CSUM, 16'h00C3);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    drain();
    write_reg(REG_SEQ_LOW, 16'h00FF);
    write_reg(REG_NONE, 16'hFFFF);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b0);
    send_byte(8'hDE, 1'b1);
    drain();
  endtask

  // Full message, then wrap with the key still running, then a restart
  task automatic test_message_wrap();
    for (int i = 0; i < MSG_BYTES + 5; i++) send_byte(8'($urandom), i == 0);
    send_byte(8'($urandom), 1'b1);
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if ($urandom_range(0, 3) != 0) write_reg(REG_SEQ_LOW, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_USER_CSUM, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_PASS_CSUM, pick_value());
      if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, pick_value());
      gaps_on = (phase % 3 != 1);
      sent = 0;
      while (sent < 220) begin
        if ($urandom_range(0, 9) < 8) begin
          // well-formed message, occasionally long enough to wrap
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(MSG_BYTES - 6, MSG_BYTES + 6)
                                             : $urandom_range(1, 40);
          for (int i = 0; i < len; i++) send_byte(8'($urandom), i == 0);
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        sent += len;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_unseeded_stream();
    test_seed_extremes();
    test_write_mid_message();
    test_message_wrap();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[lcg_keystream_xor_cipher] OK");
    end else begin
      $display("[lcg_keystream_xor_cipher] ERROR");
    end
    $finish;
  end

  // Receiver stall pattern, mode reselected whenever the low six bits of stall_tick are zero
  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_OFF:      out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 5 < 2);
      default:        out_stall <= stall_tick[4];
    endcase
  end

  always @(posedge clk) begin
    cipher_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word: data_out %02h last_byte %0b",
               out_data_out, out_last_byte);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_data_out !== want.data_out) begin
          $error("data_out mismatch: expected %02h, got %02h", want.data_out, out_data_out);
          error_count++;
        end
        if (out_last_byte !== want.last_byte) begin
          $error("last_byte mismatch: expected %0b, got %0b", want.last_byte, out_last_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[lcg_keystream_xor_cipher] ERROR");
      $finish;
    end
  end

endmodule
